// ===== sv/itef_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itef_pkg
// Shared widths, register codes, word types and sequencer states of the
// inductor track error filter.
// ----------------------------------------------------------------------------
package itef_pkg;

	// sample clamp bound and derived datapath widths
	localparam int SAMPLE_MAX  = 4096;
	localparam int SAMPLE_W    = $clog2(SAMPLE_MAX + 1);
	localparam int IN_W        = 16;
	localparam int COEF_W      = 10;
	localparam int THR_W       = 24;
	localparam int GAIN_W      = 10;
	localparam int LIMIT_W     = 15;
	localparam int ALPHA_W     = 17;
	localparam int ERR_W       = 16;
	localparam int DIFF_W      = SAMPLE_W + 2;
	localparam int NUM_W       = COEF_W + SAMPLE_W + 2;
	localparam int DEN_W       = NUM_W;
	localparam int MAG_W       = NUM_W - 1 + GAIN_W;
	localparam int RATIO_SHIFT = 8;
	localparam int DVD_W       = MAG_W + RATIO_SHIFT;
	localparam int DIV_CNT_W   = $clog2(DVD_W);
	localparam int MA_W        = ALPHA_W + 1;
	localparam int MB_W        = NUM_W;
	localparam int PROD_W      = MA_W + MB_W;
	localparam int ALPHA_SHIFT = 16;
	localparam int CMP_W       = (DEN_W > THR_W) ? DEN_W : THR_W;
	localparam int ERR_MAX     = 2 ** (ERR_W - 1) - 1;
	localparam int ERR_MIN     = -(2 ** (ERR_W - 1));

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(2 ** ALPHA_SHIFT);

	// configuration port
	localparam int REG_COUNT = 7;
	localparam int ADDR_W    = $clog2(REG_COUNT * 4);
	localparam int DATA_W    = 32;
	localparam int IDX_W     = ADDR_W - 2;

	typedef enum logic [IDX_W-1:0] {
		REG_COEFF_OUTER,
		REG_COEFF_INNER_DIFF,
		REG_COEFF_INNER_ABS,
		REG_DEN_THRESHOLD,
		REG_RATIO_GAIN,
		REG_ERROR_LIMIT,
		REG_FILTER_ALPHA
	} reg_idx_t;

	// register reset values
	localparam logic [COEF_W-1:0]  RST_COEFF_OUTER      = COEF_W'(256);
	localparam logic [COEF_W-1:0]  RST_COEFF_INNER_DIFF = COEF_W'(128);
	localparam logic [COEF_W-1:0]  RST_COEFF_INNER_ABS  = COEF_W'(256);
	localparam logic [THR_W-1:0]   RST_DEN_THRESHOLD    = THR_W'(1049);
	localparam logic [GAIN_W-1:0]  RST_RATIO_GAIN       = GAIN_W'(100);
	localparam logic [LIMIT_W-1:0] RST_ERROR_LIMIT      = LIMIT_W'(25600);
	localparam logic [ALPHA_W-1:0] RST_FILTER_ALPHA     = ALPHA_W'(19661);

	// input and result words
	typedef struct packed {
		logic                   mode;
		logic signed [IN_W-1:0] left_front;
		logic signed [IN_W-1:0] left_rear;
		logic signed [IN_W-1:0] right_rear;
		logic signed [IN_W-1:0] right_front;
	} in_word_t;

	typedef struct packed {
		logic signed [ERR_W-1:0] filtered_error;
		logic                    den_too_small;
		logic                    saturated;
	} out_word_t;

	// divider request
	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DEN_W-1:0] divisor;
	} div_req_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NUM_A,
		ST_NUM_B,
		ST_DEN_A,
		ST_DEN_B,
		ST_DEN_SUM,
		ST_CHECK,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_FILT_A,
		ST_FILT_B,
		ST_FILT_SUM,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

// ===== sv/itef_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itef_div
// Restoring unsigned divider, one quotient bit per cycle, with a one-cycle
// done pulse once the last bit is in.
// ----------------------------------------------------------------------------
module itef_div (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire itef_pkg::div_req_t      req,
	output logic                         done,
	output logic [itef_pkg::DVD_W-1:0]   quotient
);
	import itef_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0]     work_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     divisor_q;
	logic [DEN_W:0]       trial;
	logic [DEN_W:0]       rem_next;
	logic                 fits;

	// one shift-subtract step
	always_comb begin
		trial    = {rem_q, work_q[DVD_W-1]};
		fits     = trial >= {1'b0, divisor_q};
		rem_next = fits ? (trial - {1'b0, divisor_q}) : trial;
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q    <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			work_q <= {work_q[DVD_W-2:0], fits};
			rem_q  <= rem_next[DEN_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = work_q;

endmodule
`default_nettype wire

// ===== sv/inductor_track_error_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// inductor_track_error_filter
// Difference-over-sum track error from four inductor samples, saturated and
// smoothed by a first-order low-pass filter.
// ----------------------------------------------------------------------------
// One word is in work at a time. For a compute word, a shared multiplier forms
// numerator, denominator and gain product, a one-bit-per-cycle divider
// produces the DVD_W-bit quotient, and the multiplier is reused for the two
// filter taps. A word whose denominator is zero or below threshold skips the
// divider. The result sits in an output register, so the next word is taken
// while it waits. Registers are to be written over the APB port only while
// the block is idle; the user is bound by this, the block does not enforce it.
module inductor_track_error_filter (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire itef_pkg::in_word_t            in_word,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output itef_pkg::out_word_t                out_word,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [itef_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [itef_pkg::DATA_W-1:0]   pwdata,
	output logic [itef_pkg::DATA_W-1:0]        prdata,
	output logic                               pready
);
	import itef_pkg::*;

	// configuration registers
	logic [COEF_W-1:0]  coeff_outer_q;
	logic [COEF_W-1:0]  coeff_inner_diff_q;
	logic [COEF_W-1:0]  coeff_inner_abs_q;
	logic [THR_W-1:0]   den_threshold_q;
	logic [GAIN_W-1:0]  ratio_gain_q;
	logic [LIMIT_W-1:0] error_limit_q;
	logic [ALPHA_W-1:0] filter_alpha_q;

	// sequencer and datapath
	state_t                    state_q;
	state_t                    state_d;
	logic [SAMPLE_W-1:0]       lf_q;
	logic [SAMPLE_W-1:0]       lr_q;
	logic [SAMPLE_W-1:0]       rr_q;
	logic [SAMPLE_W-1:0]       rf_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [NUM_W-1:0]   acc_q;
	logic signed [NUM_W-1:0]   num_q;
	logic [DEN_W-1:0]          den_q;
	logic signed [ERR_W-1:0]   raw_q;
	logic signed [ERR_W-1:0]   filter_q;
	logic                      small_q;
	logic                      sat_q;
	logic signed [ERR_W-1:0]   res_err_q;
	logic                      out_valid_q;
	out_word_t                 out_word_q;

	logic                      accept;
	logic                      out_load;
	logic                      cfg_write;
	reg_idx_t                  cfg_idx;
	logic signed [MA_W-1:0]    mul_a;
	logic signed [MB_W-1:0]    mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic signed [DIFF_W-1:0]  diff_outer;
	logic signed [DIFF_W-1:0]  diff_inner;
	logic signed [DIFF_W-1:0]  sum_outer;
	logic signed [DIFF_W-1:0]  abs_inner;
	logic signed [NUM_W-1:0]   abs_num;
	logic [ALPHA_W-1:0]        alpha_c;
	logic signed [NUM_W-1:0]   prod_lo;
	logic signed [NUM_W-1:0]   prod_tap;
	logic signed [NUM_W-1:0]   acc_sum;
	logic signed [NUM_W:0]     filt_sum;
	logic signed [ERR_W-1:0]   filt_sat;
	logic                      den_small;
	logic                      q_over;
	logic [ERR_W-1:0]          q_mag;
	div_req_t                  div_req;
	logic                      div_done;
	logic [DVD_W-1:0]          div_quot;

	// clamp a signed sample into 0..SAMPLE_MAX
	function automatic logic [SAMPLE_W-1:0] clamp_sample(logic signed [IN_W-1:0] v);
		logic [SAMPLE_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > IN_W'(SAMPLE_MAX)) begin
			r = SAMPLE_W'(SAMPLE_MAX);
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

	// apb register file
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign cfg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_outer_q      <= RST_COEFF_OUTER;
			coeff_inner_diff_q <= RST_COEFF_INNER_DIFF;
			coeff_inner_abs_q  <= RST_COEFF_INNER_ABS;
			den_threshold_q    <= RST_DEN_THRESHOLD;
			ratio_gain_q       <= RST_RATIO_GAIN;
			error_limit_q      <= RST_ERROR_LIMIT;
			filter_alpha_q     <= RST_FILTER_ALPHA;
		end else if (cfg_write) begin
			case (cfg_idx)
				REG_COEFF_OUTER:      coeff_outer_q      <= pwdata[COEF_W-1:0];
				REG_COEFF_INNER_DIFF: coeff_inner_diff_q <= pwdata[COEF_W-1:0];
				REG_COEFF_INNER_ABS:  coeff_inner_abs_q  <= pwdata[COEF_W-1:0];
				REG_DEN_THRESHOLD:    den_threshold_q    <= pwdata[THR_W-1:0];
				REG_RATIO_GAIN:       ratio_gain_q       <= pwdata[GAIN_W-1:0];
				REG_ERROR_LIMIT:      error_limit_q      <= pwdata[LIMIT_W-1:0];
				REG_FILTER_ALPHA:     filter_alpha_q     <= pwdata[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (cfg_idx)
			REG_COEFF_OUTER:      prdata = DATA_W'(coeff_outer_q);
			REG_COEFF_INNER_DIFF: prdata = DATA_W'(coeff_inner_diff_q);
			REG_COEFF_INNER_ABS:  prdata = DATA_W'(coeff_inner_abs_q);
			REG_DEN_THRESHOLD:    prdata = DATA_W'(den_threshold_q);
			REG_RATIO_GAIN:       prdata = DATA_W'(ratio_gain_q);
			REG_ERROR_LIMIT:      prdata = DATA_W'(error_limit_q);
			REG_FILTER_ALPHA:     prdata = DATA_W'(filter_alpha_q);
			default:              prdata = '0;
		endcase
	end

	// sample combinations and operand prep
	always_comb begin
		diff_outer = $signed({2'b00, lf_q}) - $signed({2'b00, rf_q});
		diff_inner = $signed({2'b00, lr_q}) - $signed({2'b00, rr_q});
		sum_outer  = $signed({2'b00, lf_q}) + $signed({2'b00, rf_q});
		abs_inner  = diff_inner[DIFF_W-1] ? -diff_inner : diff_inner;
		abs_num    = num_q[NUM_W-1] ? -num_q : num_q;
		alpha_c    = (filter_alpha_q > ALPHA_ONE) ? ALPHA_ONE : filter_alpha_q;
		prod_lo    = prod_q[NUM_W-1:0];
		prod_tap   = prod_q[ALPHA_SHIFT +: NUM_W];
		acc_sum    = acc_q + prod_lo;
	end

	// shared multiplier
	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	// threshold and limit checks
	always_comb begin
		den_small = (den_q == '0) || (CMP_W'(den_q) < CMP_W'(den_threshold_q));
		q_over    = div_quot > DVD_W'(error_limit_q);
		q_mag     = q_over ? ERR_W'(error_limit_q) : ERR_W'(div_quot[LIMIT_W-1:0]);
	end

	// filter sum with saturation
	always_comb begin
		filt_sum = {acc_q[NUM_W-1], acc_q} + {prod_tap[NUM_W-1], prod_tap};
		if (filt_sum > (NUM_W + 1)'(ERR_MAX)) begin
			filt_sat = ERR_W'(ERR_MAX);
		end else if (filt_sum < (NUM_W + 1)'(ERR_MIN)) begin
			filt_sat = ERR_W'(ERR_MIN);
		end else begin
			filt_sat = filt_sum[ERR_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (in_valid) state_d = in_word.mode ? ST_OUT : ST_NUM_A;
			ST_NUM_A:     state_d = ST_NUM_B;
			ST_NUM_B:     state_d = ST_DEN_A;
			ST_DEN_A:     state_d = ST_DEN_B;
			ST_DEN_B:     state_d = ST_DEN_SUM;
			ST_DEN_SUM:   state_d = ST_CHECK;
			ST_CHECK:     state_d = den_small ? ST_FILT_A : ST_DIV_START;
			ST_DIV_START: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT:  if (div_done) state_d = ST_FILT_A;
			ST_FILT_A:    state_d = ST_FILT_B;
			ST_FILT_B:    state_d = ST_FILT_SUM;
			ST_FILT_SUM:  state_d = ST_OUT;
			ST_OUT:       if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: handshake, multiplier operands, divider start
	always_comb begin
		in_stall         = 1'b1;
		accept           = 1'b0;
		out_load         = 1'b0;
		mul_a            = '0;
		mul_b            = '0;
		div_req.start    = 1'b0;
		div_req.dividend = {prod_q[MAG_W-1:0], {RATIO_SHIFT{1'b0}}};
		div_req.divisor  = den_q;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				accept   = in_valid;
			end
			ST_NUM_A: begin
				mul_a = $signed(MA_W'(coeff_outer_q));
				mul_b = MB_W'(diff_outer);
			end
			ST_NUM_B: begin
				mul_a = $signed(MA_W'(coeff_inner_diff_q));
				mul_b = MB_W'(diff_inner);
			end
			ST_DEN_A: begin
				mul_a = $signed(MA_W'(coeff_outer_q));
				mul_b = MB_W'(sum_outer);
			end
			ST_DEN_B: begin
				mul_a = $signed(MA_W'(coeff_inner_abs_q));
				mul_b = MB_W'(abs_inner);
			end
			ST_CHECK: begin
				mul_a = $signed(MA_W'(ratio_gain_q));
				mul_b = abs_num;
			end
			ST_DIV_START: div_req.start = 1'b1;
			ST_FILT_A: begin
				mul_a = $signed(MA_W'(alpha_c));
				mul_b = MB_W'(raw_q);
			end
			ST_FILT_B: begin
				mul_a = $signed(MA_W'(ALPHA_ONE - alpha_c));
				mul_b = MB_W'(filter_q);
			end
			ST_OUT: out_load = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			filter_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && in_word.mode) begin
				filter_q <= '0;
			end else if (state_q == ST_FILT_SUM) begin
				filter_q <= filt_sat;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					lf_q      <= clamp_sample(in_word.left_front);
					lr_q      <= clamp_sample(in_word.left_rear);
					rr_q      <= clamp_sample(in_word.right_rear);
					rf_q      <= clamp_sample(in_word.right_front);
					res_err_q <= '0;
					small_q   <= 1'b0;
					sat_q     <= 1'b0;
				end
			end
			ST_NUM_B:   acc_q <= prod_lo;
			ST_DEN_A:   num_q <= acc_sum;
			ST_DEN_B:   acc_q <= prod_lo;
			ST_DEN_SUM: den_q <= acc_sum[DEN_W-1:0];
			ST_CHECK: begin
				small_q <= den_small;
				sat_q   <= 1'b0;
				if (den_small) begin
					raw_q <= '0;
				end
			end
			ST_DIV_WAIT: begin
				if (div_done) begin
					sat_q <= q_over;
					raw_q <= num_q[NUM_W-1] ? -$signed(q_mag) : $signed(q_mag);
				end
			end
			ST_FILT_B:   acc_q <= prod_tap;
			ST_FILT_SUM: res_err_q <= filt_sat;
			default: ;
		endcase
		if (out_load) begin
			out_word_q.filtered_error <= res_err_q;
			out_word_q.den_too_small  <= small_q;
			out_word_q.saturated      <= sat_q;
		end
	end

	// serial divider
	itef_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the inductor track error filter. Each accepted
// input word is run through a local model of the difference-over-sum error
// and its low-pass filter, and every result word is checked field by field
// against the oldest prediction. Directed words cover sample extremes,
// clears, zero denominators, saturation and filter overflow; random phases
// then sweep register settings, with random handshake idling in all but one.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import itef_pkg::*;

	localparam int     NO_REG       = REG_COUNT;
	localparam int     HOLD_CYCLES  = 300;
	localparam int     RAND_PHASES  = 6;
	localparam int     PHASE_ITEMS  = 305;
	localparam int     DRAIN_CYCLES = 60;
	localparam int     SETTLE       = 4;
	localparam longint CYCLE_LIMIT  = 1_200_000;

	localparam int REG_WIDTH [REG_COUNT] = '{COEF_W, COEF_W, COEF_W, THR_W, GAIN_W,
		LIMIT_W, ALPHA_W};

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	in_word_t          in_word  = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	out_word_t         out_word;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [ADDR_W-1:0] paddr    = '0;
	logic [DATA_W-1:0] pwdata   = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// register copy and filter state of the local model
	int     cfg [REG_COUNT] = '{RST_COEFF_OUTER, RST_COEFF_INNER_DIFF, RST_COEFF_INNER_ABS,
		RST_DEN_THRESHOLD, RST_RATIO_GAIN, RST_ERROR_LIMIT, RST_FILTER_ALPHA};
	longint track_filter = 0;

	out_word_t pending_errors [$];
	int        mismatches  = 0;
	longint    cycle_count = 0;
	bit        idle_on     = 1'b1;
	bit        hold_toggle = 1'b0;
	bit        hold_ack    = 1'b0;
	int        stall_left  = 0;

	inductor_track_error_filter dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver stalls: random bursts, plus one long hold on request
	always @(posedge clk) begin
		if (hold_toggle != hold_ack) begin
			hold_ack = hold_toggle;
			stall_left = HOLD_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 3) == 0) begin
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
				: $urandom_range(0, 3);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// result word check against the oldest prediction
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_errors.size() == 0) begin
				$error("result word with no prediction waiting: %p", out_word);
				mismatches++;
			end else begin
				want = pending_errors.pop_front();
				if (out_word.filtered_error !== want.filtered_error) begin
					$error("filtered_error: expected %0d, got %0d",
						want.filtered_error, out_word.filtered_error);
					mismatches++;
				end
				if (out_word.den_too_small !== want.den_too_small) begin
					$error("den_too_small: expected %0b, got %0b",
						want.den_too_small, out_word.den_too_small);
					mismatches++;
				end
				if (out_word.saturated !== want.saturated) begin
					$error("saturated: expected %0b, got %0b",
						want.saturated, out_word.saturated);
					mismatches++;
				end
			end
		end
	end

	function automatic longint clamp_sample(logic signed [IN_W-1:0] s);
		if (s < 0) return 0;
		if (s > SAMPLE_MAX) return SAMPLE_MAX;
		return s;
	endfunction

	// track error model: difference over sum, saturate, low-pass
	function automatic out_word_t predict_track_error(in_word_t w);
		out_word_t res;
		longint    lf, lr, rr, rf, inner, num, den, prod, quo, raw, a, f;
		res = '0;
		if (w.mode) begin
			track_filter = 0;
			return res;
		end
		lf = clamp_sample(w.left_front);
		lr = clamp_sample(w.left_rear);
		rr = clamp_sample(w.right_rear);
		rf = clamp_sample(w.right_front);
		inner = lr - rr;
		num = cfg[REG_COEFF_OUTER] * (lf - rf) + cfg[REG_COEFF_INNER_DIFF] * inner;
		den = cfg[REG_COEFF_OUTER] * (lf + rf)
			+ cfg[REG_COEFF_INNER_ABS] * (inner < 0 ? -inner : inner);
		raw = 0;
		if (den == 0 || den < cfg[REG_DEN_THRESHOLD]) begin
			res.den_too_small = 1'b1;
		end else begin
			prod = num * cfg[REG_RATIO_GAIN] * 256;
			quo = (prod < 0 ? -prod : prod) / den;
			if (quo > cfg[REG_ERROR_LIMIT]) begin
				quo = cfg[REG_ERROR_LIMIT];
				res.saturated = 1'b1;
			end
			raw = (prod < 0) ? -quo : quo;
		end
		// alpha above one acts as one; both taps floored
		a = (cfg[REG_FILTER_ALPHA] > 65536) ? 65536 : cfg[REG_FILTER_ALPHA];
		f = ((a * raw) >>> 16) + (((65536 - a) * track_filter) >>> 16);
		if (f > ERR_MAX) f = ERR_MAX;
		if (f < ERR_MIN) f = ERR_MIN;
		track_filter = f;
		res.filtered_error = ERR_W'(f);
		return res;
	endfunction

	function automatic in_word_t make_word(bit mode, int lf, int lr, int rr, int rf);
		in_word_t w;
		w.mode = mode;
		w.left_front = IN_W'(lf);
		w.left_rear = IN_W'(lr);
		w.right_rear = IN_W'(rr);
		w.right_front = IN_W'(rf);
		return w;
	endfunction

	function automatic logic signed [IN_W-1:0] random_sample();
		int edge_vals [6] = '{-32768, -1, 0, SAMPLE_MAX, SAMPLE_MAX + 1, 32767};
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) return IN_W'($urandom());
		if (pick == 1) return IN_W'(edge_vals[$urandom_range(0, 5)]);
		return IN_W'($urandom_range(0, SAMPLE_MAX));
	endfunction

	function automatic in_word_t random_word();
		in_word_t w;
		w.mode = ($urandom_range(0, 19) == 0);
		w.left_front = random_sample();
		w.left_rear = random_sample();
		w.right_rear = random_sample();
		w.right_front = random_sample();
		return w;
	endfunction

	// apb write: setup, access, then idle
	task automatic write_reg(int idx, logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx < REG_COUNT) cfg[idx] = int'(value & ((64'd1 << REG_WIDTH[idx]) - 1));
		@(posedge clk);
	endtask

	task automatic read_reg(int idx, output logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_W'(idx * 4);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		value = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// offer one word after a random gap and predict once it is taken
	task automatic send_word(in_word_t w);
		int gap;
		int pick;
		gap = 0;
		if (idle_on) begin
			pick = $urandom_range(0, 19);
			if (pick >= 18) gap = $urandom_range(8, 40);
			else if (pick >= 12) gap = $urandom_range(1, 3);
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_errors.push_back(predict_track_error(w));
	endtask

	// block idle: every predicted word has come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_errors.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic restore_defaults();
		write_reg(REG_COEFF_OUTER, RST_COEFF_OUTER);
		write_reg(REG_COEFF_INNER_DIFF, RST_COEFF_INNER_DIFF);
		write_reg(REG_COEFF_INNER_ABS, RST_COEFF_INNER_ABS);
		write_reg(REG_DEN_THRESHOLD, RST_DEN_THRESHOLD);
		write_reg(REG_RATIO_GAIN, RST_RATIO_GAIN);
		write_reg(REG_ERROR_LIMIT, RST_ERROR_LIMIT);
		write_reg(REG_FILTER_ALPHA, RST_FILTER_ALPHA);
	endtask

	function automatic logic [DATA_W-1:0] pick_value(int width);
		int pick;
		pick = $urandom_range(0, 4);
		if (pick == 0) return '0;
		if (pick == 1) return DATA_W'((64'd1 << width) - 1);
		return $urandom_range(0, (1 << width) - 1);
	endfunction

	// masking on write, read-back, and an address past the map
	task automatic test_register_access();
		logic [DATA_W-1:0] got;
		for (int i = 0; i < REG_COUNT; i++) write_reg(i, '1);
		write_reg(NO_REG, '1);
		for (int i = 0; i < REG_COUNT; i++) begin
			read_reg(i, got);
			if (got !== DATA_W'(cfg[i])) begin
				$error("register %0d: expected %0h, got %0h", i, cfg[i], got);
				mismatches++;
			end
		end
		restore_defaults();
		write_reg(NO_REG, '0);
	endtask

	// sample extremes, clamping, threshold edge and clears at reset settings
	task automatic test_directed_items();
		send_word(make_word(0, 0, 0, 0, 0));
		send_word(make_word(0, 4096, 0, 0, 0));
		send_word(make_word(0, 0, 0, 0, 4096));
		send_word(make_word(0, 32767, 0, 0, -32768));
		send_word(make_word(0, 4097, 32767, -1, -32768));
		send_word(make_word(0, 4096, 4096, 4096, 4096));
		send_word(make_word(0, 0, 4096, 0, 0));
		send_word(make_word(0, 0, 0, 4096, 0));
		send_word(make_word(0, 4, 0, 0, 0));
		send_word(make_word(0, 5, 0, 0, 0));
		send_word(make_word(1, -1, -1, -1, -1));
		send_word(make_word(1, 32767, 32767, 32767, 32767));
		send_word(make_word(0, 4096, 0, 0, 0));
		wait_idle();
	endtask

	// threshold zero lets a zero denominator through to its own check
	task automatic test_zero_denominator();
		write_reg(REG_DEN_THRESHOLD, 0);
		send_word(make_word(0, 0, 0, 0, 0));
		send_word(make_word(0, -32768, -32768, -32768, -32768));
		send_word(make_word(0, 1, 0, 0, 0));
		wait_idle();
		write_reg(REG_DEN_THRESHOLD, RST_DEN_THRESHOLD);
	endtask

	// raw error saturation, alpha above one, filter pinned at its floor
	task automatic test_saturation_and_overflow();
		write_reg(REG_COEFF_INNER_DIFF, 1023);
		write_reg(REG_COEFF_INNER_ABS, 0);
		write_reg(REG_RATIO_GAIN, 1023);
		write_reg(REG_ERROR_LIMIT, 32767);
		write_reg(REG_FILTER_ALPHA, 131071);
		send_word(make_word(0, 4096, 4096, 0, 0));
		send_word(make_word(0, 0, 0, 4096, 4096));
		wait_idle();
		write_reg(REG_FILTER_ALPHA, 1);
		send_word(make_word(0, 0, 0, 4096, 4096));
		send_word(make_word(0, 0, 0, 4096, 4096));
		wait_idle();
		write_reg(REG_ERROR_LIMIT, 0);
		send_word(make_word(0, 4096, 0, 0, 0));
		send_word(make_word(1, 0, 0, 0, 0));
		wait_idle();
		restore_defaults();
	endtask

	// long receiver hold while words keep coming
	task automatic test_backpressure();
		idle_on = 1'b0;
		hold_toggle = ~hold_toggle;
		for (int i = 0; i < 12; i++) send_word(random_word());
		wait_idle();
		idle_on = 1'b1;
	endtask

	task automatic test_random_phases();
		int pick;
		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			if (phase == 0) begin
				restore_defaults();
			end else if (phase == 1) begin
				// everything at its top, threshold out of the way
				for (int i = 0; i < REG_COUNT; i++) write_reg(i, '1);
				write_reg(REG_DEN_THRESHOLD, 0);
			end else begin
				for (int i = 0; i < REG_COUNT; i++) write_reg(i, pick_value(REG_WIDTH[i]));
				pick = $urandom_range(0, 9);
				if (pick == 0) write_reg(REG_DEN_THRESHOLD, 0);
				else if (pick == 1) write_reg(REG_DEN_THRESHOLD, (1 << THR_W) - 1);
				else write_reg(REG_DEN_THRESHOLD, $urandom_range(0, 1 << 18));
			end
			idle_on = (phase != 2);
			for (int i = 0; i < PHASE_ITEMS; i++) send_word(random_word());
			wait_idle();
		end
		idle_on = 1'b1;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_access();
		test_directed_items();
		test_zero_denominator();
		test_saturation_and_overflow();
		test_backpressure();
		test_random_phases();
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/itef_pkg.sv
sv/itef_div.sv
sv/inductor_track_error_filter.sv
tb/testbench.sv
